### hw/rtl/tactile_window_std_classifier_top_assert.svh
// Assertion macros for the classifier top level
`ifndef TACTILE_WINDOW_STD_CLASSIFIER_TOP_ASSERT_SVH
`define TACTILE_WINDOW_STD_CLASSIFIER_TOP_ASSERT_SVH

// property holds at every clock edge outside reset
`define TWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition never occurs outside reset
`define TWSC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/twsc_pkg.sv
// Types and constants of the tactile window classifier
package twsc_pkg;

  typedef struct packed {
    logic signed [15:0] force_one;
    logic signed [15:0] force_two;
    logic signed [15:0] force_three;
    logic signed [15:0] torque_one;
    logic signed [15:0] torque_two;
    logic signed [15:0] torque_three;
    logic signed [15:0] tip_prox_one;
    logic signed [15:0] tip_prox_two;
    logic signed [15:0] tip_prox_three;
    logic signed [15:0] pad_prox_one;
    logic signed [15:0] pad_prox_two;
    logic signed [15:0] pad_prox_three;
  } twsc_in_t;

  typedef struct packed {
    logic [1:0] class_one;
    logic [1:0] class_two;
    logic [1:0] class_three;
    logic       calibrated;
  } twsc_out_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } twsc_cfg_t;

  typedef enum logic [2:0] {
    REG_FORCE_COEF  = 3'd0,
    REG_TORQUE_COEF = 3'd1,
    REG_SCORE_BIAS  = 3'd2,
    REG_AMB_THR     = 3'd3,
    REG_PROX_TRIG   = 3'd4
  } twsc_reg_index_t;

  typedef enum logic [1:0] {
    CLS_UNDECIDED = 2'd0,
    CLS_SOFT      = 2'd1,
    CLS_HARD      = 2'd2
  } twsc_class_t;

  typedef struct packed {
    logic signed [15:0] force_coef;
    logic signed [15:0] torque_coef;
    logic signed [15:0] score_bias;
    logic [14:0]        amb_thr;
    logic signed [15:0] prox_trig;
  } twsc_regs_t;

  localparam logic signed [15:0] FORCE_COEF_RST  = -16'sd21557;
  localparam logic signed [15:0] TORQUE_COEF_RST = -16'sd11923;
  localparam logic signed [15:0] SCORE_BIAS_RST  = 16'sd609;
  localparam logic [14:0]        AMB_THR_RST     = 15'd51;
  localparam logic signed [15:0] PROX_TRIG_RST   = -16'sd512;

  localparam int FINGERS  = 3;
  localparam int CHANNELS = 6;

  typedef enum logic [2:0] {
    LN_IDLE, LN_OLD, LN_ACC, LN_MUL, LN_NUM, LN_SQRT, LN_DONE
  } twsc_lane_state_t;

  typedef enum logic [1:0] {
    T_IDLE, T_RUN, T_MERGE, T_HOLD
  } twsc_top_state_t;

endpackage

### hw/rtl/twsc_if.sv
// Handshake interfaces for sample, result and configuration words
interface twsc_in_if import twsc_pkg::*; ();
  logic     valid;
  logic     ready;
  twsc_in_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface twsc_out_if import twsc_pkg::*; ();
  logic      valid;
  logic      ready;
  twsc_out_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface twsc_cfg_if import twsc_pkg::*; ();
  logic      valid;
  logic      ready;
  twsc_cfg_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/twsc_lane.sv
// One channel lane: sample window, running sums, serial root search on the scaled variance
module twsc_lane import twsc_pkg::*; #(
  parameter int WINDOW = 128,
  localparam int AW = $clog2(WINDOW)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               full,
  input  logic [AW-1:0]      slot,
  input  logic signed [15:0] x,
  output logic               done,
  output logic [15:0]        std_dev
);

  localparam int  LW      = $clog2(WINDOW);
  localparam int  SW      = 17 + LW;
  localparam int  QW      = 31 + LW;
  localparam int  NW      = 31 + 2 * LW;
  localparam longint DIVISOR = longint'(WINDOW) * longint'(WINDOW - 1);
  localparam int  DW      = $clog2(DIVISOR + 1);
  localparam int  RW      = DW + 34;
  localparam logic [RW-1:0] STEP_TOP = RW'(DIVISOR) << 30;

  twsc_lane_state_t state, state_next;

  logic signed [15:0] mem [WINDOW];
  logic signed [15:0] rd, xr, oldr;
  logic               full_r;
  logic [31:0]        xsq, oldsq;
  logic signed [SW-1:0] sum;
  logic [QW-1:0]      sumsq;
  logic [NW-1:0]      prod_a, prod_b, numer;
  logic signed [2*SW-1:0] sum_sq;
  logic [RW-1:0]      acc_sq, step_a, step_b, trial;
  logic               take;
  logic [3:0]         cnt;
  logic [15:0]        root;

  // root bit k is kept when D*(r + 2^k)^2 <= numer; step_a = D*r << (k+1), step_b = D << 2k
  assign sum_sq = sum * sum;
  assign trial  = acc_sq + step_a + step_b;
  assign take   = trial <= RW'(numer);

  always_comb begin
    state_next = state;
    unique case (state)
      LN_IDLE: if (start) state_next = LN_OLD;
      LN_OLD:  state_next = LN_ACC;
      LN_ACC:  state_next = LN_MUL;
      LN_MUL:  state_next = LN_NUM;
      LN_NUM:  state_next = LN_SQRT;
      LN_SQRT: if (cnt == 4'd15) state_next = LN_DONE;
      LN_DONE: state_next = LN_IDLE;
      default: state_next = LN_IDLE;
    endcase
  end

  always_comb begin
    done = (state == LN_DONE);
  end

  assign std_dev = root;

  always_ff @(posedge clk) begin
    if (state == LN_IDLE && start) begin
      rd        <= mem[slot];
      mem[slot] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
      sum   <= '0;
      sumsq <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        LN_IDLE: if (start) begin
          xr     <= x;
          full_r <= full;
          xsq    <= 32'(x * x);
        end
        LN_OLD: begin
          oldr  <= rd;
          oldsq <= 32'(rd * rd);
        end
        LN_ACC: begin
          sum   <= sum + SW'(xr) - (full_r ? SW'(oldr) : SW'(0));
          sumsq <= sumsq + QW'(xsq) - (full_r ? QW'(oldsq) : QW'(0));
        end
        LN_MUL: begin
          prod_a <= NW'(sumsq) * NW'(WINDOW);
          prod_b <= NW'(sum_sq);
        end
        LN_NUM: begin
          numer  <= (prod_a >= prod_b) ? prod_a - prod_b : '0;
          acc_sq <= '0;
          step_a <= '0;
          step_b <= STEP_TOP;
          root   <= '0;
          cnt    <= '0;
        end
        LN_SQRT: begin
          if (take) begin
            acc_sq <= trial;
            step_a <= (step_a >> 1) + step_b;
          end else begin
            step_a <= step_a >> 1;
          end
          step_b <= step_b >> 2;
          root   <= {root[14:0], take};
          cnt    <= cnt + 1'b1;
        end
        LN_DONE: ;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/twsc_merge.sv
// Merge stage: per-finger score from force and torque deviations, then class
module twsc_merge import twsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] std_f [FINGERS],
  input  logic [15:0] std_t [FINGERS],
  input  logic [FINGERS-1:0] trig,
  input  logic        cal,
  input  twsc_regs_t  regs,
  output twsc_class_t cls [FINGERS],
  output logic        done
);

  logic               v1;
  logic signed [32:0] pf [FINGERS];
  logic signed [32:0] pt [FINGERS];
  logic signed [33:0] tot [FINGERS];
  logic signed [22:0] score [FINGERS];

  always_comb begin
    for (int i = 0; i < FINGERS; i++) begin
      tot[i]   = 34'(pf[i]) + 34'(pt[i]);
      score[i] = 23'(tot[i] >>> 12) + 23'(regs.score_bias);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FINGERS; i++) begin
      if (start) begin
        pf[i] <= regs.force_coef * $signed({1'b0, std_f[i]});
        pt[i] <= regs.torque_coef * $signed({1'b0, std_t[i]});
      end
      if (v1) begin
        if (!cal || !trig[i]) cls[i] <= CLS_UNDECIDED;
        else if (score[i] > $signed({8'd0, regs.amb_thr})) cls[i] <= CLS_HARD;
        else cls[i] <= CLS_SOFT;
      end
    end
  end

endmodule

### hw/rtl/tactile_window_std_classifier_top.sv
// Path of a sample word, the same for any WINDOW: from the accepting edge it passes the lanes
// (sum update, numerator, 16 root steps, done), then merge, then the output load to result valid.
// Input reopens only once the result word of the last sample sits in the output register,
// and a result word still waiting there holds off the next load.
// Reset: synchronous, clears sums, fill count, slot, calibrated flag and registers
// to their defaults; window memory is not cleared, only values from written slots are used.
module tactile_window_std_classifier_top import twsc_pkg::*; #(
  parameter int WINDOW = 128
) (
  input logic       clk,
  input logic       rst,
  twsc_in_if.sink   sample,
  twsc_out_if.source result,
  twsc_cfg_if.sink  cfg
);

`include "tactile_window_std_classifier_top_assert.svh"

  localparam int AW  = $clog2(WINDOW);
  localparam int FCW = $clog2(WINDOW + 1);

  twsc_top_state_t state, state_next;
  twsc_regs_t      regs;
  logic [FCW-1:0]  fill_count;
  logic [AW-1:0]   slot;
  logic            cal;
  logic [FINGERS-1:0] trig;
  logic            full, accept, merge_start, load_out, merge_done;
  logic signed [15:0] xs [CHANNELS];
  logic [CHANNELS-1:0] lane_done;
  logic            lanes_done;
  logic [15:0]     stds [CHANNELS];
  logic [15:0]     std_f [FINGERS];
  logic [15:0]     std_t [FINGERS];
  twsc_class_t     cls [FINGERS];
  logic signed [15:0] tips [FINGERS];
  logic signed [15:0] pads [FINGERS];

  assign full   = (fill_count == FCW'(WINDOW));
  assign accept = sample.valid && sample.ready;
  assign cfg.ready = 1'b1;
  assign lanes_done = &lane_done;

  assign xs[0] = sample.data.force_one;
  assign xs[1] = sample.data.force_two;
  assign xs[2] = sample.data.force_three;
  assign xs[3] = sample.data.torque_one;
  assign xs[4] = sample.data.torque_two;
  assign xs[5] = sample.data.torque_three;
  assign tips[0] = sample.data.tip_prox_one;
  assign tips[1] = sample.data.tip_prox_two;
  assign tips[2] = sample.data.tip_prox_three;
  assign pads[0] = sample.data.pad_prox_one;
  assign pads[1] = sample.data.pad_prox_two;
  assign pads[2] = sample.data.pad_prox_three;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    twsc_lane #(.WINDOW(WINDOW)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .start   (accept),
      .full    (full),
      .slot    (slot),
      .x       (xs[c]),
      .done    (lane_done[c]),
      .std_dev (stds[c])
    );
  end

  for (genvar f = 0; f < FINGERS; f++) begin : g_fing
    assign std_f[f] = stds[f];
    assign std_t[f] = stds[f + FINGERS];
  end

  twsc_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (merge_start),
    .std_f (std_f),
    .std_t (std_t),
    .trig  (trig),
    .cal   (cal),
    .regs  (regs),
    .cls   (cls),
    .done  (merge_done)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (accept) state_next = T_RUN;
      T_RUN:   if (lanes_done) state_next = T_MERGE;
      T_MERGE: if (merge_done) state_next = T_HOLD;
      T_HOLD:  if (!result.valid || result.ready) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = (state == T_IDLE);
    merge_start  = (state == T_RUN) && lanes_done;
    load_out     = (state == T_HOLD) && (!result.valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      fill_count   <= '0;
      slot         <= '0;
      cal          <= 1'b0;
      result.valid <= 1'b0;
      regs.force_coef  <= FORCE_COEF_RST;
      regs.torque_coef <= TORQUE_COEF_RST;
      regs.score_bias  <= SCORE_BIAS_RST;
      regs.amb_thr     <= AMB_THR_RST;
      regs.prox_trig   <= PROX_TRIG_RST;
    end else begin
      state <= state_next;
      if (accept) begin
        slot <= (slot == AW'(WINDOW - 1)) ? '0 : slot + 1'b1;
        if (full) cal <= 1'b1;
        else fill_count <= fill_count + 1'b1;
      end
      if (load_out) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_FORCE_COEF:  regs.force_coef  <= cfg.data.value;
          REG_TORQUE_COEF: regs.torque_coef <= cfg.data.value;
          REG_SCORE_BIAS:  regs.score_bias  <= cfg.data.value;
          REG_AMB_THR:     regs.amb_thr     <= cfg.data.value[14:0];
          REG_PROX_TRIG:   regs.prox_trig   <= cfg.data.value;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int f = 0; f < FINGERS; f++) begin
        trig[f] <= (tips[f] > regs.prox_trig) || (pads[f] > regs.prox_trig);
      end
    end
    if (load_out) begin
      result.data.class_one   <= cls[0];
      result.data.class_two   <= cls[1];
      result.data.class_three <= cls[2];
      result.data.calibrated  <= cal;
    end
  end

  `TWSC_NEVER(a_done_only_run, lanes_done && state != T_RUN, "lane done outside run")
  `TWSC_ASSERT(a_accept_run, accept |=> state == T_RUN, "accept did not start run")
  `TWSC_NEVER(a_no_overwrite, load_out && result.valid && !result.ready, "result overwritten")

endmodule
